### sv/jbt_pkg.sv
// Shared types and constants of the JSON byte tokenizer.
package jbt_pkg;

  localparam int unsigned PosBits = 24;

  typedef logic [PosBits-1:0] pos_t;

  typedef enum logic [3:0] {
    TokUnknown  = 4'd0,
    TokEnd      = 4'd1,
    TokLBrace   = 4'd2,
    TokRBrace   = 4'd3,
    TokLBracket = 4'd4,
    TokRBracket = 4'd5,
    TokComma    = 4'd6,
    TokColon    = 4'd7,
    TokTrue     = 4'd8,
    TokFalse    = 4'd9,
    TokNull     = 4'd10,
    TokString   = 4'd11
  } tok_kind_e;

  typedef enum logic [2:0] {
    ErrNone         = 3'd0,
    ErrUnterminated = 3'd1,
    ErrBadUnicode   = 3'd2,
    ErrBadEscape    = 3'd3,
    ErrBadKeyword   = 3'd4,
    ErrUnknownChar  = 3'd5
  } tok_err_e;

  typedef struct packed {
    tok_kind_e kind;
    tok_err_e  err;
    pos_t      start;
    pos_t      len;
    pos_t      line;
    pos_t      col;
  } tok_t;

  // All tokens caused by one input byte; tok1 is valid only when two is set.
  typedef struct packed {
    logic two;
    tok_t tok0;
    tok_t tok1;
  } tok_pair_t;

endpackage

### sv/jbt_lexer.sv
// Front end: accepts bytes, tracks lexer state and builds the tokens of each byte.
module jbt_lexer import jbt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic      in_end_i,
  input  logic      push_ready_i,
  output logic      push_valid_o,
  output tok_pair_t push_data_o
);

  localparam logic [2:0] ModeIdle    = 3'd0;
  localparam logic [2:0] ModeAfterCr = 3'd1;
  localparam logic [2:0] ModeKeyword = 3'd2;
  localparam logic [2:0] ModeString  = 3'd3;
  localparam logic [2:0] ModeEscape  = 3'd4;
  localparam logic [2:0] ModeHex     = 3'd5;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLowU   = 8'h75;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam pos_t       PosMax   = '1;

  logic [2:0] mode_q, mode_d;
  logic [1:0] hex_q, hex_d;
  logic [2:0] cand_q, cand_d;
  logic [2:0] lett_q, lett_d;
  tok_err_e   perr_q, perr_d;
  pos_t       so_q, so_d;
  pos_t       sl_q, sl_d;
  pos_t       sc_q, sc_d;
  pos_t       bp_q, bp_d;
  pos_t       ln_q, ln_d;
  pos_t       cl_q, cl_d;

  logic       accept;
  logic [1:0] cnt;
  tok_t       t0, t1;
  logic       done;
  tok_kind_e  kwk;
  tok_err_e   kwe;
  tok_kind_e  pk;

  function automatic pos_t sat_inc(pos_t v);
    return (v == PosMax) ? PosMax : v + pos_t'(1);
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic is_simple_esc(logic [7:0] c);
    return c == 8'h62 || c == 8'h66 || c == 8'h6E || c == 8'h72 || c == 8'h74 ||
           c == ChBslash || c == ChQuote || c == 8'h27;
  endfunction

  function automatic logic [2:0] kw_len(logic [1:0] k);
    return (k == 2'd1) ? 3'd5 : 3'd4;
  endfunction

  function automatic tok_kind_e kw_kind(logic [1:0] k);
    tok_kind_e r;
    unique case (k)
      2'd0:    r = TokTrue;
      2'd1:    r = TokFalse;
      default: r = TokNull;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] kw_char(logic [1:0] k, logic [2:0] idx);
    logic [39:0] w;
    unique case (k)
      2'd0:    w = {8'h00, 8'h65, 8'h75, 8'h72, 8'h74};
      2'd1:    w = {8'h65, 8'h73, 8'h6C, 8'h61, 8'h66};
      default: w = {8'h00, 8'h6C, 8'h6C, 8'h75, 8'h6E};
    endcase
    return (idx < 3'd5) ? w[idx*8 +: 8] : 8'h00;
  endfunction

  function automatic logic [2:0] kw_step(logic [2:0] cand, logic [2:0] lett,
                                         logic [7:0] c);
    logic [2:0] r;
    r = cand;
    for (int k = 0; k < 3; k++) begin
      if (lett >= kw_len(2'(k)) || kw_char(2'(k), lett) != c) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic tok_t make_tok(tok_kind_e kind, tok_err_e err, pos_t so, pos_t bp,
                                    pos_t sl, pos_t sc);
    tok_t t;
    t.kind  = kind;
    t.err   = err;
    t.start = so;
    t.len   = bp - so;
    t.line  = sl;
    t.col   = sc;
    return t;
  endfunction

  assign accept     = in_valid_i && push_ready_i;
  assign in_ready_o = push_ready_i;

  always_comb begin
    mode_d = mode_q;
    hex_d  = hex_q;
    cand_d = cand_q;
    lett_d = lett_q;
    perr_d = perr_q;
    so_d   = so_q;
    sl_d   = sl_q;
    sc_d   = sc_q;
    bp_d   = bp_q;
    ln_d   = ln_q;
    cl_d   = cl_q;
    cnt    = 2'd0;
    t0     = '0;
    t1     = '0;
    done   = 1'b0;
    pk     = TokUnknown;

    kwk = TokUnknown;
    kwe = ErrBadKeyword;
    for (int k = 0; k < 3; k++) begin
      if (kwk == TokUnknown && cand_q[k] && lett_q == kw_len(2'(k))) begin
        kwk = kw_kind(2'(k));
        kwe = perr_q;
      end
    end

    if (in_end_i) begin
      if (mode_q == ModeKeyword) begin
        t0  = make_tok(kwk, kwe, so_q, bp_q, sl_q, sc_q);
        cnt = 2'd1;
      end else if (mode_q == ModeString || mode_q == ModeEscape || mode_q == ModeHex) begin
        t0  = make_tok(TokString, ErrUnterminated, so_q, bp_q, sl_q, sc_q);
        cnt = 2'd1;
      end
      if (cnt == 2'd0) begin
        t0 = make_tok(TokEnd, ErrNone, bp_q, bp_q, ln_q, cl_q);
      end else begin
        t1 = make_tok(TokEnd, ErrNone, bp_q, bp_q, ln_q, cl_q);
      end
      cnt    = cnt + 2'd1;
      mode_d = ModeIdle;
      hex_d  = '0;
      cand_d = '1;
      lett_d = '0;
      perr_d = ErrNone;
      so_d   = '0;
      sl_d   = pos_t'(1);
      sc_d   = '0;
      bp_d   = '0;
      ln_d   = pos_t'(1);
      cl_d   = '0;
    end else begin
      if (mode_d == ModeHex && !is_hex(in_byte_i)) begin
        perr_d = ErrBadUnicode;
        hex_d  = '0;
        mode_d = ModeString;
      end
      if (mode_d == ModeKeyword && !is_letter(in_byte_i)) begin
        t0     = make_tok(kwk, kwe, so_d, bp_d, sl_d, sc_d);
        cnt    = 2'd1;
        mode_d = ModeIdle;
      end else if (mode_d == ModeString && in_byte_i == ChLf) begin
        t0     = make_tok(TokString, ErrUnterminated, so_d, bp_d, sl_d, sc_d);
        cnt    = 2'd1;
        mode_d = ModeIdle;
      end else if (mode_d == ModeAfterCr) begin
        mode_d = ModeIdle;
        if (in_byte_i == ChLf) begin
          bp_d = sat_inc(bp_d);
          ln_d = sat_inc(ln_d);
          cl_d = pos_t'(1);
          done = 1'b1;
        end
      end

      if (!done) begin
        unique case (mode_d)
          ModeKeyword: begin
            bp_d   = sat_inc(bp_d);
            cl_d   = sat_inc(cl_d);
            cand_d = kw_step(cand_d, lett_d, in_byte_i);
            if (lett_d < 3'd7) begin
              lett_d = lett_d + 3'd1;
            end
          end
          ModeString: begin
            bp_d = sat_inc(bp_d);
            cl_d = sat_inc(cl_d);
            if (in_byte_i == ChQuote) begin
              t0     = make_tok(TokString, perr_d, so_d, bp_d, sl_d, sc_d);
              cnt    = 2'd1;
              mode_d = ModeIdle;
            end else if (in_byte_i == ChBslash) begin
              mode_d = ModeEscape;
            end
          end
          ModeEscape: begin
            bp_d = sat_inc(bp_d);
            cl_d = sat_inc(cl_d);
            if (is_simple_esc(in_byte_i)) begin
              mode_d = ModeString;
            end else if (in_byte_i == ChLowU) begin
              hex_d  = '0;
              mode_d = ModeHex;
            end else begin
              perr_d = ErrBadEscape;
              mode_d = ModeString;
            end
          end
          ModeHex: begin
            bp_d = sat_inc(bp_d);
            cl_d = sat_inc(cl_d);
            if (hex_d == 2'd3) begin
              hex_d  = '0;
              mode_d = ModeString;
            end else begin
              hex_d = hex_d + 2'd1;
            end
          end
          default: begin
            mode_d = ModeIdle;
            if (in_byte_i == ChSpace) begin
              bp_d = sat_inc(bp_d);
              cl_d = sat_inc(cl_d);
            end else if (in_byte_i == ChCr) begin
              bp_d   = sat_inc(bp_d);
              cl_d   = sat_inc(cl_d);
              mode_d = ModeAfterCr;
            end else if (in_byte_i == ChLf) begin
              bp_d = sat_inc(bp_d);
              ln_d = sat_inc(ln_d);
              cl_d = pos_t'(1);
            end else begin
              so_d   = bp_d;
              sl_d   = ln_d;
              sc_d   = cl_d;
              perr_d = ErrNone;
              bp_d   = sat_inc(bp_d);
              cl_d   = sat_inc(cl_d);
              case (in_byte_i)
                8'h7B:   pk = TokLBrace;
                8'h7D:   pk = TokRBrace;
                8'h5B:   pk = TokLBracket;
                8'h5D:   pk = TokRBracket;
                8'h2C:   pk = TokComma;
                8'h3A:   pk = TokColon;
                default: pk = TokUnknown;
              endcase
              if (pk != TokUnknown || (in_byte_i != ChQuote && !is_letter(in_byte_i))) begin
                if (cnt == 2'd0) begin
                  t0 = make_tok(pk, (pk == TokUnknown) ? ErrUnknownChar : ErrNone,
                                so_d, bp_d, sl_d, sc_d);
                end else begin
                  t1 = make_tok(pk, (pk == TokUnknown) ? ErrUnknownChar : ErrNone,
                                so_d, bp_d, sl_d, sc_d);
                end
                cnt = cnt + 2'd1;
              end else if (in_byte_i == ChQuote) begin
                mode_d = ModeString;
              end else begin
                cand_d = kw_step(3'b111, 3'd0, in_byte_i);
                lett_d = 3'd1;
                mode_d = ModeKeyword;
              end
            end
          end
        endcase
      end
    end
  end

  assign push_valid_o     = accept && (cnt != 2'd0);
  assign push_data_o.two  = (cnt == 2'd2);
  assign push_data_o.tok0 = t0;
  assign push_data_o.tok1 = t1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      hex_q  <= '0;
      cand_q <= '1;
      lett_q <= '0;
      perr_q <= ErrNone;
      so_q   <= '0;
      sl_q   <= pos_t'(1);
      sc_q   <= '0;
      bp_q   <= '0;
      ln_q   <= pos_t'(1);
      cl_q   <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      hex_q  <= hex_d;
      cand_q <= cand_d;
      lett_q <= lett_d;
      perr_q <= perr_d;
      so_q   <= so_d;
      sl_q   <= sl_d;
      sc_q   <= sc_d;
      bp_q   <= bp_d;
      ln_q   <= ln_d;
      cl_q   <= cl_d;
    end
  end

  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_end_i) |=> (mode_q == ModeIdle && bp_q == '0 && ln_q == pos_t'(1)))
    else $error("state not cleared after end of document");

  a_hex_only_in_hex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hex_q != 2'd0) |-> (mode_q == ModeHex))
    else $error("hex digit count outside a unicode escape");

  a_end_always_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_end_i) |-> push_valid_o)
    else $error("end of document produced no end token");

endmodule

### sv/jbt_queue.sv
// Short token queue between the lexer and the output stage.
module jbt_queue import jbt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  tok_pair_t push_data_i,
  output logic      push_ready_o,
  input  logic      pop_i,
  output logic      head_valid_o,
  output tok_pair_t head_data_o
);

  localparam int unsigned Depth   = 4;
  localparam int unsigned PtrBits = $clog2(Depth);

  tok_pair_t           mem_q [Depth];
  logic [PtrBits-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PtrBits:0]    cnt_q;
  logic                do_push, do_pop;

  assign push_ready_o = (cnt_q != (PtrBits+1)'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_data_o  = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrBits'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrBits'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (PtrBits+1)'(1);
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - (PtrBits+1)'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrBits+1)'(Depth))
    else $error("queue fill count beyond its depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> push_ready_o)
    else $error("push into a full queue");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree while empty");

endmodule

### sv/jbt_emitter.sv
// Back end: sends the one or two tokens of each queue entry as separate transfers.
module jbt_emitter import jbt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  tok_pair_t head_data_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output tok_t      out_tok_o,
  output logic      out_last_o
);

  logic sel_q;
  logic fire;

  assign out_valid_o = head_valid_i;
  assign out_tok_o   = sel_q ? head_data_i.tok1 : head_data_i.tok0;
  assign out_last_o  = !head_data_i.two || sel_q;
  assign fire        = head_valid_i && out_ready_i;
  assign pop_o       = fire && out_last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else if (fire) begin
      sel_q <= !out_last_o;
    end
  end

  a_sel_needs_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> (head_valid_i && head_data_i.two))
    else $error("second token selected without a two-token entry");

  a_pop_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (fire && out_last_o))
    else $error("entry released before its last token");

  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !out_last_o) |=> (sel_q && head_valid_i))
    else $error("second token of an entry lost");

endmodule

### sv/json_byte_tokenizer_core.sv
// Top level of the JSON byte tokenizer: lexer, token queue and output stage.
// The block takes one byte of JSON text per transfer on the slave side, at up to one byte
// per clock cycle, with tlast marking the end of a document (its data byte is ignored).
// Each byte is classified in the cycle it is accepted; the tokens it completes go into a
// four-entry registered queue and leave on the master side one token per transfer. A byte
// that completes two tokens (a keyword ended by punctuation or an unknown character, or the
// end of document after a pending token) occupies the output for two transfers, so the
// sustained rate is one byte per cycle as long as tokens leave at least as fast as they
// are made; otherwise the queue fills and tready drops. tlast on the master side marks the
// last token caused by one input byte. Positions, lines and columns saturate at 2^24-1.
module json_byte_tokenizer_core import jbt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  input  logic [7:0]   s_tdata_i,   // data_byte
  input  logic         s_tlast_i,   // end_of_input
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  // token_type[3:0], error_code[6:4], start_index[30:7], token_length[54:31],
  // start_line[78:55], start_column[102:79], zero pad[103]
  output logic [103:0] m_tdata_o,
  output logic         m_tlast_o    // last_of_run
);

  logic      push_valid, push_ready, pop, head_valid;
  tok_pair_t push_data, head_data;
  tok_t      out_tok;

  jbt_lexer u_lexer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_tvalid_i),
    .in_ready_o   (s_tready_o),
    .in_byte_i    (s_tdata_i),
    .in_end_i     (s_tlast_i),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_data_o  (push_data)
  );

  jbt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_data_o  (head_data)
  );

  jbt_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_data_i  (head_data),
    .pop_o        (pop),
    .out_valid_o  (m_tvalid_o),
    .out_ready_i  (m_tready_i),
    .out_tok_o    (out_tok),
    .out_last_o   (m_tlast_o)
  );

  assign m_tdata_o = {1'b0, out_tok.col, out_tok.line, out_tok.len, out_tok.start,
                      out_tok.err, out_tok.kind};

endmodule

### dv/tb_json_byte_tokenizer_core.sv
// Self-checking testbench for the JSON byte tokenizer core, driven by two directed documents and random JSON-like text.
`timescale 1ns / 100ps

module tb_json_byte_tokenizer_core import jbt_pkg::*;;

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam int unsigned TargetItems = 1600;
  localparam int unsigned CycleLimit  = 300000;

  class token_tracker;
    typedef enum int {LxIdle, LxAfterCr, LxKeyword, LxString, LxEscape, LxHex} lex_mode_e;
    typedef struct {
      tok_t tok;
      logic last;
    } token_rec_t;

    token_rec_t tokens_due[$];
    int         mismatches;
    lex_mode_e  mode;
    int         hex_seen;
    logic [2:0] kw_cand;
    int         kw_letters;
    tok_err_e   pend_err;
    pos_t       tok_start, tok_line, tok_col;
    pos_t       byte_pos, line_no, col_no;
    string      kw_word[3];
    tok_kind_e  kw_kind[3];

    function new();
      kw_word = '{"true", "false", "null"};
      kw_kind = '{TokTrue, TokFalse, TokNull};
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      mode = LxIdle;
      hex_seen = 0;
      kw_cand = 3'b111;
      kw_letters = 0;
      pend_err = ErrNone;
      tok_start = '0;
      tok_line = pos_t'(1);
      tok_col = '0;
      byte_pos = '0;
      line_no = pos_t'(1);
      col_no = '0;
    endfunction

    function int pending();
      return tokens_due.size();
    endfunction

    function pos_t bump(pos_t v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_hex(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function void advance();
      byte_pos = bump(byte_pos);
      col_no = bump(col_no);
    endfunction

    function void line_break();
      line_no = bump(line_no);
      col_no = pos_t'(1);
    endfunction

    function void open_token();
      tok_start = byte_pos;
      tok_line = line_no;
      tok_col = col_no;
      pend_err = ErrNone;
    endfunction

    function void push(tok_kind_e k, tok_err_e e);
      token_rec_t r;
      r.tok.kind = k;
      r.tok.err = e;
      r.tok.start = tok_start;
      r.tok.len = byte_pos - tok_start;
      r.tok.line = tok_line;
      r.tok.col = tok_col;
      r.last = 1'b0;
      tokens_due.push_back(r);
    endfunction

    function void kw_step(logic [7:0] c);
      for (int k = 0; k < 3; k++) begin
        if (kw_letters >= kw_word[k].len() || kw_word[k][kw_letters] != c) kw_cand[k] = 1'b0;
      end
      if (kw_letters < 7) kw_letters++;
    endfunction

    function void close_keyword();
      for (int k = 0; k < 3; k++) begin
        if (kw_cand[k] && kw_letters == kw_word[k].len()) begin
          push(kw_kind[k], pend_err);
          return;
        end
      end
      push(TokUnknown, ErrBadKeyword);
    endfunction

    // Notes one accepted input transfer and queues the tokens it completes.
    function void take_byte(logic [7:0] c, logic eoi);
      int        n0;
      bit        done;
      tok_kind_e t;
      n0 = tokens_due.size();
      if (eoi) begin
        if (mode == LxKeyword) begin
          close_keyword();
        end else if (mode == LxString || mode == LxEscape || mode == LxHex) begin
          push(TokString, ErrUnterminated);
        end
        open_token();
        push(TokEnd, ErrNone);
        clear();
      end else begin
        done = 1'b0;
        while (!done) begin
          case (mode)
            LxKeyword: begin
              if (is_letter(c)) begin
                advance();
                kw_step(c);
                done = 1'b1;
              end else begin
                close_keyword();
                mode = LxIdle;
              end
            end
            LxAfterCr: begin
              mode = LxIdle;
              if (c == ChLf) begin
                advance();
                line_break();
                done = 1'b1;
              end
            end
            LxString: begin
              if (c == ChQuote) begin
                advance();
                push(TokString, pend_err);
                mode = LxIdle;
                done = 1'b1;
              end else if (c == ChLf) begin
                push(TokString, ErrUnterminated);
                mode = LxIdle;
              end else begin
                advance();
                if (c == ChBackslash) mode = LxEscape;
                done = 1'b1;
              end
            end
            LxEscape: begin
              advance();
              if (c inside {"b", "f", "n", "r", "t", ChBackslash, ChQuote, "'"}) begin
                mode = LxString;
              end else if (c == "u") begin
                hex_seen = 0;
                mode = LxHex;
              end else begin
                pend_err = ErrBadEscape;
                mode = LxString;
              end
              done = 1'b1;
            end
            LxHex: begin
              if (is_hex(c)) begin
                advance();
                if (hex_seen >= 3) begin
                  hex_seen = 0;
                  mode = LxString;
                end else begin
                  hex_seen++;
                end
                done = 1'b1;
              end else begin
                pend_err = ErrBadUnicode;
                hex_seen = 0;
                mode = LxString;
              end
            end
            default: begin
              mode = LxIdle;
              done = 1'b1;
              if (c == ChSpace) begin
                advance();
              end else if (c == ChCr) begin
                advance();
                mode = LxAfterCr;
              end else if (c == ChLf) begin
                advance();
                line_break();
              end else begin
                open_token();
                advance();
                case (c)
                  "{": t = TokLBrace;
                  "}": t = TokRBrace;
                  "[": t = TokLBracket;
                  "]": t = TokRBracket;
                  ",": t = TokComma;
                  ":": t = TokColon;
                  default: t = TokUnknown;
                endcase
                if (t != TokUnknown) begin
                  push(t, ErrNone);
                end else if (c == ChQuote) begin
                  mode = LxString;
                end else if (is_letter(c)) begin
                  kw_cand = 3'b111;
                  kw_letters = 0;
                  kw_step(c);
                  mode = LxKeyword;
                end else begin
                  push(TokUnknown, ErrUnknownChar);
                end
              end
            end
          endcase
        end
      end
      if (tokens_due.size() > n0) tokens_due[tokens_due.size()-1].last = 1'b1;
    endfunction

    function void compare_field(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        mismatches++;
      end
    endfunction

    // Checks one token transfer against the oldest expected token.
    function void check_token(logic [103:0] d, logic last);
      token_rec_t want;
      if (tokens_due.size() == 0) begin
        $error("token transfer with none expected: tdata %h", d);
        mismatches++;
        return;
      end
      want = tokens_due.pop_front();
      compare_field("token_type", want.tok.kind, d[3:0]);
      compare_field("error_code", want.tok.err, d[6:4]);
      compare_field("start_index", want.tok.start, d[30:7]);
      compare_field("token_length", want.tok.len, d[54:31]);
      compare_field("start_line", want.tok.line, d[78:55]);
      compare_field("start_column", want.tok.col, d[102:79]);
      compare_field("pad", 0, d[103]);
      compare_field("last_of_run", want.last, last);
    endfunction
  endclass

  logic         clk;
  logic         rst_n = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'h00;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic         m_tlast;

  token_tracker tracker = new();
  logic [7:0]   doc_q[$];
  int           sent_items = 0;
  int           cycle_count = 0;
  bit           tx_fast = 1'b0;
  bit           rx_fast = 1'b0;
  int           rx_hold = 0;

  json_byte_tokenizer_core uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tlast_i  (s_tlast),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata),
    .m_tlast_o  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] rand_letter();
    return 8'($urandom_range(0, 25)) + (($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41);
  endfunction

  function automatic string pick_keyword();
    case ($urandom_range(0, 2))
      0: return "true";
      1: return "false";
      default: return "null";
    endcase
  endfunction

  function automatic void add_word(input string w);
    for (int i = 0; i < w.len(); i++) doc_q.push_back(w[i]);
  endfunction

  function automatic void add_space();
    case ($urandom_range(0, 3))
      0: doc_q.push_back(ChSpace);
      1: begin
        doc_q.push_back(ChCr);
        doc_q.push_back(ChLf);
      end
      2: doc_q.push_back(ChLf);
      default: doc_q.push_back(ChCr);
    endcase
  endfunction

  function automatic void add_bad_keyword();
    string w;
    int    n;
    w = pick_keyword();
    case ($urandom_range(0, 3))
      0: begin
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) doc_q.push_back(rand_letter());
      end
      1: begin
        n = $urandom_range(1, w.len() - 1);
        for (int i = 0; i < n; i++) doc_q.push_back(w[i]);
      end
      2: begin
        add_word(w);
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) doc_q.push_back(rand_letter());
      end
      default: begin
        n = $urandom_range(0, w.len() - 1);
        w[n] = w[n] ^ 8'h20;
        add_word(w);
      end
    endcase
  endfunction

  function automatic void add_hex(input int n);
    for (int i = 0; i < n; i++) doc_q.push_back(pick("0123456789abcdefABCDEF"));
  endfunction

  function automatic void add_string_body();
    logic [7:0] b;
    int         n;
    n = $urandom_range(0, 6);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        4: begin
          doc_q.push_back(ChBackslash);
          doc_q.push_back(pick("bfnrt\\\"'"));
        end
        5, 6: begin
          add_word("\\u");
          add_hex(4);
        end
        7: begin
          add_word("\\u");
          add_hex($urandom_range(0, 3));
          do b = 8'($urandom_range(0, 255));
          while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F"));
          doc_q.push_back(b);
        end
        8: begin
          doc_q.push_back(ChBackslash);
          if ($urandom_range(0, 3) == 0) begin
            b = ChLf;
          end else begin
            do b = 8'($urandom_range(0, 255));
            while (b inside {"b", "f", "n", "r", "t", "u", ChBackslash, ChQuote, "'"});
          end
          doc_q.push_back(b);
        end
        9: begin
          if ($urandom_range(0, 2) == 0) doc_q.push_back(ChLf);
        end
        default: begin
          do b = 8'($urandom_range(0, 255));
          while (b inside {ChQuote, ChBackslash, ChLf});
          doc_q.push_back(b);
        end
      endcase
    end
  endfunction

  function automatic void add_unknown();
    case ($urandom_range(0, 2))
      0: doc_q.push_back(pick("0123456789-.+\t"));
      1: doc_q.push_back(8'($urandom_range(0, 31)));
      default: doc_q.push_back(8'($urandom_range(127, 255)));
    endcase
  endfunction

  // Mostly well-formed token sequences with random content, some raw noise.
  function automatic void build_doc();
    int n;
    doc_q.delete();
    if ($urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 16);
      for (int i = 0; i < n; i++) doc_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 15))
        0, 1, 2, 3, 4: doc_q.push_back(pick("{}[],:"));
        5, 6, 14: add_space();
        7, 8: add_word(pick_keyword());
        9: add_bad_keyword();
        13: add_unknown();
        default: begin
          doc_q.push_back(ChQuote);
          add_string_body();
          doc_q.push_back(ChQuote);
        end
      endcase
    end
    case ($urandom_range(0, 7))
      0: begin
        doc_q.push_back(ChQuote);
        add_string_body();
      end
      1: add_word("\"a\\");
      2: begin
        add_word("\"\\u");
        add_hex($urandom_range(0, 3));
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(input logic [7:0] b, input logic eoi);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= eoi;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.take_byte(b, eoi);
    sent_items++;
  endtask

  task automatic send_doc(input bit with_end);
    foreach (doc_q[i]) send_item(doc_q[i], 1'b0);
    if (with_end) send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic drain_tokens();
    s_tvalid <= 1'b0;
    do @(posedge clk);
    while (tracker.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin : token_sink
    int stall;
    m_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      stall = rx_fast ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      tracker.check_token(m_tdata, m_tlast);
    end
  end

  initial begin : text_source
    int doc_no;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Keyword closed by a quote, bad escape, short unicode escape, lone CR and a high byte.
    doc_q.delete();
    add_word("[true\"\\q\\u1x\"");
    doc_q.push_back(ChCr);
    doc_q.push_back(8'hFF);
    send_doc(1'b1);
    // New line, NUL byte, bad keyword before a string, and end of text after a backslash.
    doc_q.delete();
    add_word("{}:");
    doc_q.push_back(ChLf);
    doc_q.push_back(8'h00);
    add_word("nu\"\\");
    send_doc(1'b1);
    drain_tokens();

    doc_no = 0;
    while (sent_items < TargetItems) begin
      doc_no++;
      tx_fast = ($urandom_range(0, 3) == 0);
      rx_fast = ($urandom_range(0, 4) == 0);
      if (doc_no == 20) begin
        tx_fast = 1'b1;
        rx_hold = 400;
      end
      build_doc();
      send_doc($urandom_range(0, 9) != 0);
      if (doc_no % 30 == 10) drain_tokens();
    end

    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
